[sv/simplest_dyadic_between_unit_assert.svh]
// Assertion macros shared by the simplest dyadic between unit.
`ifndef SIMPLEST_DYADIC_BETWEEN_UNIT_ASSERT_SVH
`define SIMPLEST_DYADIC_BETWEEN_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define SDB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle check failed.");
`define SDB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle check failed.");
`else
`define SDB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SDB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[sv/sdb_pkg.sv]
// Shared constants and controller/datapath interface types.
package sdb_pkg;

    localparam int EXP_W = 5;
    localparam int RES_W = 33;

    typedef struct packed {
        logic load;
        logic prep;
        logic align;
        logic cmp;
        logic test;
        logic shift;
        logic fin;
    } t_sdb_cmd;

    typedef struct packed {
        logic normal;
        logic less;
        logic is_int;
        logic converged;
    } t_sdb_sts;

endpackage

[sv/sdb_dpath.sv]
// Datapath: bound alignment, integer test and the bit-serial refinement shifter.
module sdb_dpath #(
    parameter int NUM_WIDTH = 32,
    parameter int EXP_MAX   = 30
) (
    input  logic                             i_clk,
    input  logic signed [NUM_WIDTH-1:0]      i_left_num,
    input  logic [sdb_pkg::EXP_W-1:0]        i_left_exp,
    input  logic signed [NUM_WIDTH-1:0]      i_right_num,
    input  logic [sdb_pkg::EXP_W-1:0]        i_right_exp,
    input  sdb_pkg::t_sdb_cmd                i_cmd,
    output sdb_pkg::t_sdb_sts                o_sts,
    output logic                             o_found,
    output logic signed [sdb_pkg::RES_W-1:0] o_result_num,
    output logic [sdb_pkg::EXP_W-1:0]        o_result_exp
);
    import sdb_pkg::*;

    localparam int EXP_TOP = (2 ** EXP_W) - 1;
    localparam int EMAX    = (EXP_MAX > EXP_TOP) ? EXP_TOP : EXP_MAX;
    localparam int AW      = NUM_WIDTH + EMAX + 1;
    localparam logic [EXP_W-1:0] EMAX_E = EXP_W'(EMAX);

    typedef enum logic [1:0] {
        CLS_NORMAL,
        CLS_ZERO,
        CLS_NONE
    } t_cls;

    logic [NUM_WIDTH-1:0] r_ln;
    logic [NUM_WIDTH-1:0] r_rn;
    logic [EXP_W-1:0]     r_le;
    logic [EXP_W-1:0]     r_re;
    logic [NUM_WIDTH-1:0] r_a;
    logic [NUM_WIDTH-1:0] r_b;
    logic [EXP_W-1:0]     r_ea;
    logic [EXP_W-1:0]     r_eb;
    logic [EXP_W-1:0]     r_e;
    logic                 r_neg;
    t_cls                 r_cls;
    logic [AW-1:0]        r_wa;
    logic [AW-1:0]        r_wb;
    logic [NUM_WIDTH-1:0] r_fl;
    logic [NUM_WIDTH-1:0] r_fl1;
    logic [AW-1:0]        r_thr;
    logic                 r_less;
    logic                 r_int;
    logic [EXP_W:0]       r_rexp;

    logic [EXP_W-1:0]     n_le;
    logic [EXP_W-1:0]     n_re;
    logic                 ln_neg;
    logic                 rn_neg;
    logic                 rn_zero;
    logic [NUM_WIDTH-1:0] neg_ln;
    logic [NUM_WIDTH-1:0] neg_rn;
    t_cls                 n_cls;
    logic [AW-1:0]        emask;
    logic [RES_W-1:0]     mag;
    logic [RES_W-1:0]     snum;

    assign n_le    = (i_left_exp > EMAX_E) ? EMAX_E : i_left_exp;
    assign n_re    = (i_right_exp > EMAX_E) ? EMAX_E : i_right_exp;
    assign ln_neg  = r_ln[NUM_WIDTH-1];
    assign rn_neg  = r_rn[NUM_WIDTH-1];
    assign rn_zero = (r_rn == '0);
    assign neg_ln  = -r_ln;
    assign neg_rn  = -r_rn;
    assign emask   = ~({AW{1'b1}} << r_e);
    assign mag     = r_int ? RES_W'(r_fl1) : RES_W'(r_wb);
    assign snum    = r_neg ? -mag : mag;

    always_comb begin
        priority if (ln_neg && !rn_neg && !rn_zero) begin
            n_cls = CLS_ZERO;
        end else if (!ln_neg && rn_neg) begin
            n_cls = CLS_NONE;
        end else begin
            n_cls = CLS_NORMAL;
        end
    end

    assign o_sts.normal    = (r_cls == CLS_NORMAL);
    assign o_sts.less      = r_less;
    assign o_sts.is_int    = r_int;
    assign o_sts.converged = (r_wa[AW-1:1] == r_wb[AW-1:1]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ln <= i_left_num;
            r_rn <= i_right_num;
            r_le <= n_le;
            r_re <= n_re;
        end
        // Left bound negative: mirror around zero and negate the answer.
        if (i_cmd.prep) begin
            r_cls <= n_cls;
            r_e   <= (r_le > r_re) ? r_le : r_re;
            if (!ln_neg) begin
                r_a   <= r_ln;
                r_ea  <= r_le;
                r_b   <= r_rn;
                r_eb  <= r_re;
                r_neg <= 1'b0;
            end else begin
                r_a   <= neg_rn;
                r_ea  <= r_re;
                r_b   <= neg_ln;
                r_eb  <= r_le;
                r_neg <= 1'b1;
            end
        end
        if (i_cmd.align) begin
            r_wa <= AW'(r_a) << (r_e - r_ea);
            r_wb <= AW'(r_b) << (r_e - r_eb);
            r_fl <= r_a >> r_ea;
        end
        if (i_cmd.cmp) begin
            r_less <= (r_wa < r_wb);
            r_thr  <= (r_wa | emask) + AW'(1);
            r_fl1  <= r_fl + NUM_WIDTH'(1);
        end
        // The bounds become open odd numerators at one more bit of scale.
        if (i_cmd.test) begin
            r_int  <= (r_wb > r_thr);
            r_wa   <= {r_wa[AW-2:0], 1'b1};
            r_wb   <= (r_wb << 1) - AW'(1);
            r_rexp <= (EXP_W + 1)'(r_e) + (EXP_W + 1)'(1);
        end
        if (i_cmd.shift) begin
            r_wa   <= r_wa >> 1;
            r_wb   <= r_wb >> 1;
            r_rexp <= r_rexp - (EXP_W + 1)'(1);
        end
        if (i_cmd.fin) begin
            priority if (r_cls == CLS_ZERO) begin
                o_found      <= 1'b1;
                o_result_num <= '0;
                o_result_exp <= '0;
            end else if ((r_cls == CLS_NONE) || !r_less) begin
                o_found      <= 1'b0;
                o_result_num <= '0;
                o_result_exp <= '0;
            end else begin
                o_found      <= 1'b1;
                o_result_num <= snum;
                o_result_exp <= r_int ? '0 : r_rexp[EXP_W-1:0];
            end
        end
    end

endmodule

[sv/sdb_ctrl.sv]
// Controller: sequences one word through the datapath and strobes the result.
`include "simplest_dyadic_between_unit_assert.svh"

module sdb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output logic              o_done,
    output sdb_pkg::t_sdb_cmd o_cmd,
    input  sdb_pkg::t_sdb_sts i_sts
);
    import sdb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_ALIGN,
        S_CMP,
        S_TEST,
        S_RUN,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   r_done;
    logic   stop;

    assign stop = !i_sts.normal || !i_sts.less || i_sts.is_int || i_sts.converged;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start) begin
                n_state = S_PREP;
            end
            S_PREP:  n_state = S_ALIGN;
            S_ALIGN: n_state = S_CMP;
            S_CMP:   n_state = S_TEST;
            S_TEST:  n_state = S_RUN;
            S_RUN:   if (stop) begin
                n_state = S_FIN;
            end
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.load  = (r_state == S_IDLE) && i_start;
        o_cmd.prep  = (r_state == S_PREP);
        o_cmd.align = (r_state == S_ALIGN);
        o_cmd.cmp   = (r_state == S_CMP);
        o_cmd.test  = (r_state == S_TEST);
        o_cmd.shift = (r_state == S_RUN) && !stop;
        o_cmd.fin   = (r_state == S_FIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            r_done  <= (r_state == S_FIN);
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

    `SDB_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `SDB_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !o_busy)
    `SDB_ASSERT_NXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `SDB_ASSERT_NXT(a_run_stop, i_clk, i_rst_n, (r_state == S_RUN) && stop, r_state == S_FIN)

endmodule

[sv/simplest_dyadic_between_unit.sv]
// Top level of the simplest dyadic between unit.
// Finds the simplest dyadic rational strictly between two bounds num/2^exp and returns it
// reduced, with o_found low when the left bound is not below the right one. A word is taken
// when start is high and busy is low; the result appears on the o_ ports for exactly one
// cycle with o_done high and must be captured then, since the receiver cannot stall it.
// After the accepting edge the controller steps through the prep, align, compare, test,
// run and fin states; the time spent in run is set by the refinement shifter, which drops
// one bit of both scaled bounds per cycle until they share all but their lowest bit.
// A new word may be accepted in the cycle the strobe is high.
module simplest_dyadic_between_unit #(
    parameter int NUM_WIDTH = 32,
    parameter int EXP_MAX   = 30
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [NUM_WIDTH-1:0]      i_left_num,
    input  logic [sdb_pkg::EXP_W-1:0]        i_left_exp,
    input  logic signed [NUM_WIDTH-1:0]      i_right_num,
    input  logic [sdb_pkg::EXP_W-1:0]        i_right_exp,
    output logic                             o_done,
    output logic                             o_found,
    output logic signed [sdb_pkg::RES_W-1:0] o_result_num,
    output logic [sdb_pkg::EXP_W-1:0]        o_result_exp
);
    import sdb_pkg::*;

    t_sdb_cmd cmd;
    t_sdb_sts sts;

    sdb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    sdb_dpath #(
        .NUM_WIDTH (NUM_WIDTH),
        .EXP_MAX   (EXP_MAX)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_left_num   (i_left_num),
        .i_left_exp   (i_left_exp),
        .i_right_num  (i_right_num),
        .i_right_exp  (i_right_exp),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_found      (o_found),
        .o_result_num (o_result_num),
        .o_result_exp (o_result_exp)
    );

endmodule
